[rtl/igrf_pkg.sv]
`timescale 1ns / 1ps

package igrf_pkg;

  // sizes
  localparam int STORE_BYTES_DEF = 256;
  localparam int MAX_GROUP       = 8;
  localparam int LANE_W          = 3;
  localparam int BYTE_W          = 8;
  localparam int INDEX_W         = 16;
  localparam int START_W         = 14;
  localparam int LEN_W           = 9;
  localparam int REQ_W           = 3;
  localparam int ACT_W           = 2;
  localparam int SIG_W           = 3;
  localparam int CFG_IDX_W       = 1;
  localparam int CMP_W           = INDEX_W + 1;

  // index loaded when the address is matched (two bytes before zero)
  localparam logic [INDEX_W-1:0] ADDR_PHASE_START = 16'hFFFE;

  // group masks for 1, 2, 4 and 8 byte groups
  localparam logic [LANE_W-1:0] GRP_MASK_1 = 3'd0;
  localparam logic [LANE_W-1:0] GRP_MASK_2 = 3'd1;
  localparam logic [LANE_W-1:0] GRP_MASK_4 = 3'd3;
  localparam logic [LANE_W-1:0] GRP_MASK_8 = 3'd7;

  // bus events
  typedef enum logic [REQ_W-1:0] {
    REQ_ADDR_MATCH = 3'd0,
    REQ_BYTE_RX    = 3'd1,
    REQ_BYTE_TX    = 3'd2,
    REQ_READ_NACK  = 3'd3,
    REQ_STOP       = 3'd4,
    REQ_BUS_ERROR  = 3'd5,
    REQ_FAULT      = 3'd6
  } req_type_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_ACK     = 2'd0,
    ACT_NACK    = 2'd1,
    ACT_RELEASE = 2'd2
  } bus_action_t;

  typedef enum logic {
    ERR_MISALIGNED = 1'b0,
    ERR_BUS        = 1'b1
  } error_kind_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_READ,
    PH_EXEC
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_READABLE_LEN = 1'b0,
    CFG_WRITABLE_LEN = 1'b1
  } cfg_reg_t;

  // one store row holds one eight byte group
  typedef logic [MAX_GROUP-1:0][BYTE_W-1:0] row_t;

  // row write request towards the byte store
  typedef struct packed {
    logic                 en;
    logic [MAX_GROUP-1:0] be;
    row_t                 data;
  } st_wr_t;

  // group size field of the address word to group mask
  function automatic logic [LANE_W-1:0] grp_mask_of(input logic [1:0] sel);
    logic [LANE_W-1:0] m;
    unique case (sel)
      2'd0: m = GRP_MASK_1;
      2'd1: m = GRP_MASK_2;
      2'd2: m = GRP_MASK_4;
      2'd3: m = GRP_MASK_8;
    endcase
    return m;
  endfunction

endpackage

[rtl/igrf_in_if.sv]
`timescale 1ns / 1ps

// bus event channel
interface igrf_in_if;
  logic                        valid;
  logic                        ready;
  logic [igrf_pkg::REQ_W-1:0]  req_type;
  logic [igrf_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

[rtl/igrf_out_if.sv]
`timescale 1ns / 1ps

// result channel
interface igrf_out_if;
  logic                        valid;
  logic                        ready;
  logic [igrf_pkg::ACT_W-1:0]  bus_action;
  logic                        tx_valid;
  logic [igrf_pkg::BYTE_W-1:0] tx_byte;
  logic                        signal_valid;
  logic [igrf_pkg::SIG_W-1:0]  signal_code;
  logic                        error_valid;
  logic                        error_kind;

  modport source (output valid, output bus_action, output tx_valid, output tx_byte,
                  output signal_valid, output signal_code, output error_valid,
                  output error_kind, input ready);
  modport sink   (input valid, input bus_action, input tx_valid, input tx_byte,
                  input signal_valid, input signal_code, input error_valid,
                  input error_kind, output ready);
endinterface

[rtl/i2c_target_grouped_register_file.sv]
`timescale 1ns / 1ps
// an event passes the read phase, a registered row read of the byte store, then the execute
// phase, which loads its result into the output register; a new event is taken only in idle
// or as the previous one executes, even while an earlier result still waits on the output
// register. reset: synchronous, active low; then a clearing pass over ceil(STORE_BYTES/8)
// rows zeroes the store, with in_chan.ready low; configuration writes are taken throughout
module i2c_target_grouped_register_file #(
  parameter int STORE_BYTES = igrf_pkg::STORE_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  igrf_in_if.sink                        in_chan,
  igrf_out_if.source                     out_chan,
  input  logic                           cfg_we,
  input  logic [igrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [igrf_pkg::LEN_W-1:0]     cfg_wdata
);

  localparam int ROWS  = (STORE_BYTES + igrf_pkg::MAX_GROUP - 1) / igrf_pkg::MAX_GROUP;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [ROW_W-1:0] st_row;
  igrf_pkg::st_wr_t st_wr;
  igrf_pkg::row_t   rd_data;
  logic             clr_busy;

  // event sequencing, state and result register
  igrf_core #(
    .STORE_BYTES (STORE_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .clr_busy  (clr_busy),
    .st_row    (st_row),
    .rd_data   (rd_data),
    .st_wr     (st_wr)
  );

  // byte store, eight bytes to a row
  igrf_store #(
    .STORE_BYTES (STORE_BYTES)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .row      (st_row),
    .wr       (st_wr),
    .rd_data  (rd_data),
    .clr_busy (clr_busy)
  );

endmodule

[rtl/igrf_store.sv]
`timescale 1ns / 1ps

module igrf_store #(
  parameter int   STORE_BYTES = igrf_pkg::STORE_BYTES_DEF,
  localparam int  ROWS        = (STORE_BYTES + igrf_pkg::MAX_GROUP - 1) / igrf_pkg::MAX_GROUP,
  localparam int  ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [ROW_W-1:0]     row,
  input  igrf_pkg::st_wr_t     wr,
  output igrf_pkg::row_t       rd_data,
  output logic                 clr_busy
);

  igrf_pkg::row_t   mem [ROWS];
  igrf_pkg::row_t   rd_data_r;
  logic             clr_busy_r;
  logic [ROW_W-1:0] clr_row_r;

  // clearing sweep after reset, one row a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_row_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_row_r == ROW_W'(ROWS - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_row_r <= clr_row_r + 1'b1;
    end
  end

  // row array with byte enables and registered read
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_row_r] <= '0;
    end else if (wr.en) begin
      for (int l = 0; l < igrf_pkg::MAX_GROUP; l++) begin
        if (wr.be[l]) begin
          mem[row][l] <= wr.data[l];
        end
      end
    end
    rd_data_r <= mem[row];
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

[rtl/igrf_core.sv]
`timescale 1ns / 1ps

module igrf_core #(
  parameter int   STORE_BYTES = igrf_pkg::STORE_BYTES_DEF,
  localparam int  ROWS        = (STORE_BYTES + igrf_pkg::MAX_GROUP - 1) / igrf_pkg::MAX_GROUP,
  localparam int  ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  igrf_in_if.sink                        in_chan,
  igrf_out_if.source                     out_chan,
  input  logic                           cfg_we,
  input  logic [igrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [igrf_pkg::LEN_W-1:0]     cfg_wdata,
  input  logic                           clr_busy,
  output logic [ROW_W-1:0]               st_row,
  input  igrf_pkg::row_t                 rd_data,
  output igrf_pkg::st_wr_t               st_wr
);

  localparam int LW = igrf_pkg::LANE_W;
  localparam int NG = igrf_pkg::MAX_GROUP;

  // configuration
  logic [igrf_pkg::LEN_W-1:0]   rlen_r, wlen_r;

  // control
  igrf_pkg::phase_t             ph_r, ph_nxt;
  logic                         in_take, exec_go;

  // event register
  igrf_pkg::req_type_t          ev_req_r;
  logic [igrf_pkg::BYTE_W-1:0]  ev_rx_r;

  // block state
  logic [igrf_pkg::INDEX_W-1:0] idx_r, idx_nxt, idx_inc;
  logic [LW-1:0]                gmask_r, gmask_nxt;
  igrf_pkg::row_t               gbuf_r, gbuf_nxt;

  // result register
  logic                         out_valid_r;
  igrf_pkg::bus_action_t        act_r, act_nxt;
  logic                         txv_r, txv_nxt;
  logic [igrf_pkg::BYTE_W-1:0]  txb_r, txb_nxt;
  logic                         sigv_r, sigv_nxt;
  logic [igrf_pkg::SIG_W-1:0]   sigc_r, sigc_nxt;
  logic                         errv_r, errv_nxt;
  igrf_pkg::error_kind_t        errk_r, errk_nxt;

  // datapath helpers
  logic [NG-1:0]                lane_ok;
  igrf_pkg::row_t               rd_byte;
  logic [NG-1:0][LW-1:0]        snap_lane;
  logic                         wr_ok, rd_ok;
  logic [igrf_pkg::INDEX_W-1:0] addr_word;
  igrf_pkg::st_wr_t             wr_c;

  // handshake
  assign exec_go        = (ph_r == igrf_pkg::PH_EXEC) && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !clr_busy && ((ph_r == igrf_pkg::PH_IDLE) || exec_go);
  assign in_take        = in_chan.valid && in_chan.ready;

  // phase register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= igrf_pkg::PH_IDLE;
    end else begin
      ph_r <= ph_nxt;
    end
  end

  // phase sequencing: read the row, then execute
  always_comb begin
    ph_nxt = ph_r;
    unique case (ph_r)
      igrf_pkg::PH_IDLE: if (in_take) ph_nxt = igrf_pkg::PH_READ;
      igrf_pkg::PH_READ: ph_nxt = igrf_pkg::PH_EXEC;
      igrf_pkg::PH_EXEC: begin
        if (in_take) begin
          ph_nxt = igrf_pkg::PH_READ;
        end else if (exec_go) begin
          ph_nxt = igrf_pkg::PH_IDLE;
        end
      end
      default: ph_nxt = igrf_pkg::PH_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rlen_r <= '0;
      wlen_r <= '0;
    end else if (cfg_we) begin
      unique case (igrf_pkg::cfg_reg_t'(cfg_index))
        igrf_pkg::CFG_READABLE_LEN: rlen_r <= cfg_wdata;
        igrf_pkg::CFG_WRITABLE_LEN: wlen_r <= cfg_wdata;
      endcase
    end
  end

  // event capture
  always_ff @(posedge clk) begin
    if (in_take) begin
      ev_req_r <= igrf_pkg::req_type_t'(in_chan.req_type);
      ev_rx_r  <= in_chan.rx_byte;
    end
  end

  // store row of the current index, masked where past the store end
  assign st_row = idx_r[LW +: ROW_W];

  always_comb begin
    for (int l = 0; l < NG; l++) begin
      lane_ok[l]   = {1'b0, idx_r[igrf_pkg::INDEX_W-1:LW], LW'(l)}
                     < igrf_pkg::CMP_W'(STORE_BYTES);
      rd_byte[l]   = lane_ok[l] ? rd_data[l] : '0;
      snap_lane[l] = idx_r[LW-1:0] + LW'(l);
    end
  end

  // signed index against the length limits
  assign idx_inc = idx_r + 1'b1;
  assign wr_ok   = idx_r[igrf_pkg::INDEX_W-1] ||
                   (idx_r < igrf_pkg::INDEX_W'(wlen_r));
  assign rd_ok   = !idx_r[igrf_pkg::INDEX_W-1] &&
                   (idx_r < igrf_pkg::INDEX_W'(rlen_r));

  // event execution
  always_comb begin
    idx_nxt   = idx_r;
    gmask_nxt = gmask_r;
    gbuf_nxt  = gbuf_r;
    addr_word = '0;
    wr_c      = '0;
    act_nxt   = igrf_pkg::ACT_ACK;
    txv_nxt   = 1'b0;
    txb_nxt   = '0;
    sigv_nxt  = 1'b0;
    sigc_nxt  = '0;
    errv_nxt  = 1'b0;
    errk_nxt  = igrf_pkg::ERR_MISALIGNED;
    unique case (ev_req_r)
      igrf_pkg::REQ_ADDR_MATCH: begin
        idx_nxt   = igrf_pkg::ADDR_PHASE_START;
        gmask_nxt = igrf_pkg::GRP_MASK_2;
      end
      igrf_pkg::REQ_BYTE_RX: begin
        if (wr_ok) begin
          idx_nxt = idx_inc;
          if (gmask_r == igrf_pkg::GRP_MASK_1) begin
            // single byte straight into the store
            wr_c.en = 1'b1;
            for (int l = 0; l < NG; l++) begin
              wr_c.be[l]   = (idx_r[LW-1:0] == LW'(l)) && lane_ok[l];
              wr_c.data[l] = ev_rx_r;
            end
          end else begin
            gbuf_nxt[idx_r[LW-1:0] & gmask_r] = ev_rx_r;
            if (idx_inc == '0) begin
              // address word complete
              addr_word = {gbuf_nxt[1], gbuf_nxt[0]};
              if (&addr_word[igrf_pkg::INDEX_W-1:igrf_pkg::SIG_W]) begin
                sigv_nxt = 1'b1;
                sigc_nxt = addr_word[igrf_pkg::SIG_W-1:0];
              end else begin
                idx_nxt   = igrf_pkg::INDEX_W'(addr_word[igrf_pkg::START_W-1:0]);
                gmask_nxt = igrf_pkg::grp_mask_of(
                              addr_word[igrf_pkg::INDEX_W-1:igrf_pkg::START_W]);
                if ((addr_word[LW-1:0] & gmask_nxt) != '0) begin
                  errv_nxt = 1'b1;
                  errk_nxt = igrf_pkg::ERR_MISALIGNED;
                  act_nxt  = igrf_pkg::ACT_NACK;
                end
              end
            end else if ((idx_inc[LW-1:0] & gmask_r) == '0) begin
              // group complete: commit it in one row write
              wr_c.en = 1'b1;
              for (int l = 0; l < NG; l++) begin
                wr_c.be[l]   = ((LW'(l) & ~gmask_r) == (idx_r[LW-1:0] & ~gmask_r)) &&
                               lane_ok[l];
                wr_c.data[l] = gbuf_nxt[LW'(l) & gmask_r];
              end
            end
          end
        end
      end
      igrf_pkg::REQ_BYTE_TX: begin
        txv_nxt = 1'b1;
        if (rd_ok) begin
          idx_nxt = idx_inc;
          if (gmask_r == igrf_pkg::GRP_MASK_1) begin
            txb_nxt = rd_byte[idx_r[LW-1:0]];
          end else begin
            // snapshot on the first byte of a group
            if ((idx_r[LW-1:0] & gmask_r) == '0) begin
              for (int k = 0; k < NG; k++) begin
                if (LW'(k) <= gmask_r) begin
                  gbuf_nxt[k] = rd_byte[snap_lane[k]];
                end
              end
            end
            txb_nxt = gbuf_nxt[idx_r[LW-1:0] & gmask_r];
          end
        end
      end
      igrf_pkg::REQ_READ_NACK, igrf_pkg::REQ_STOP: begin
      end
      igrf_pkg::REQ_BUS_ERROR: begin
        act_nxt = igrf_pkg::ACT_RELEASE;
      end
      igrf_pkg::REQ_FAULT: begin
        errv_nxt = 1'b1;
        errk_nxt = igrf_pkg::ERR_BUS;
        act_nxt  = igrf_pkg::ACT_NACK;
      end
      default: begin
        act_nxt = igrf_pkg::ACT_NACK;
      end
    endcase
  end

  assign st_wr = exec_go ? wr_c : '0;

  // state update on execution
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      gmask_r <= igrf_pkg::GRP_MASK_1;
      gbuf_r  <= '0;
    end else if (exec_go) begin
      idx_r   <= idx_nxt;
      gmask_r <= gmask_nxt;
      gbuf_r  <= gbuf_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_go) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      act_r  <= act_nxt;
      txv_r  <= txv_nxt;
      txb_r  <= txb_nxt;
      sigv_r <= sigv_nxt;
      sigc_r <= sigc_nxt;
      errv_r <= errv_nxt;
      errk_r <= errk_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.bus_action   = act_r;
  assign out_chan.tx_valid     = txv_r;
  assign out_chan.tx_byte      = txb_r;
  assign out_chan.signal_valid = sigv_r;
  assign out_chan.signal_code  = sigc_r;
  assign out_chan.error_valid  = errv_r;
  assign out_chan.error_kind   = errk_r;

endmodule

[test/igrf_reply_check.sv]
`timescale 1ns / 1ps

module igrf_reply_check (
  input  logic                           clk,
  input  logic                           rst_n,
  igrf_in_if                             in_mon,
  igrf_out_if                            out_mon,
  input  logic                           cfg_we,
  input  logic [igrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [igrf_pkg::LEN_W-1:0]     cfg_wdata,
  output int                             mismatches,
  output int                             outstanding
);
  import igrf_pkg::*;

  localparam int MEM_AW = $clog2(STORE_BYTES_DEF);

  // one reply per bus event
  typedef struct packed {
    bus_action_t       bus_action;
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              signal_valid;
    logic [SIG_W-1:0]  signal_code;
    logic              error_valid;
    error_kind_t       error_kind;
  } event_reply_t;

  // shadow of the target state
  logic [BYTE_W-1:0]  mem_copy [STORE_BYTES_DEF];
  logic [BYTE_W-1:0]  grp_bytes [MAX_GROUP];
  logic [INDEX_W-1:0] ptr;
  logic [LANE_W-1:0]  grp_mask;
  logic [LEN_W-1:0]   rd_limit;
  logic [LEN_W-1:0]   wr_limit;

  event_reply_t replies_due [$];
  event_reply_t due;

  function automatic logic [BYTE_W-1:0] mem_read(input int addr);
    return (addr < STORE_BYTES_DEF) ? mem_copy[addr[MEM_AW-1:0]] : '0;
  endfunction

  function automatic void mem_write(input int addr, input logic [BYTE_W-1:0] b);
    if (addr < STORE_BYTES_DEF) mem_copy[addr[MEM_AW-1:0]] = b;
  endfunction

  // advance the shadow state by one bus event and work out its reply
  function automatic event_reply_t serve_event(input logic [REQ_W-1:0] req,
                                               input logic [BYTE_W-1:0] rx);
    event_reply_t       r;
    logic [LANE_W-1:0]  m;
    logic [INDEX_W-1:0] word;
    logic [INDEX_W-1:0] base;
    int                 pos;
    int                 k;
    r   = '0;
    m   = grp_mask;
    pos = ptr[INDEX_W-1] ? int'(ptr) - 65536 : int'(ptr);
    case (req)
      REQ_ADDR_MATCH: begin
        ptr      = ADDR_PHASE_START;
        grp_mask = GRP_MASK_2;
      end
      REQ_BYTE_RX: begin
        if (pos < int'(wr_limit)) begin
          if (m == GRP_MASK_1) begin
            mem_write(int'(ptr), rx);
            ptr = ptr + 1'b1;
          end else begin
            grp_bytes[ptr[LANE_W-1:0] & m] = rx;
            ptr = ptr + 1'b1;
            if (ptr == '0) begin
              // address word complete: signal command or new start and group size
              word = {grp_bytes[1], grp_bytes[0]};
              if ((word | 16'h0007) == 16'hFFFF) begin
                r.signal_valid = 1'b1;
                r.signal_code  = word[SIG_W-1:0];
              end else begin
                ptr      = {2'b00, word[START_W-1:0]};
                grp_mask = LANE_W'((1 << word[INDEX_W-1:START_W]) - 1);
                if ((ptr[LANE_W-1:0] & grp_mask) != '0) begin
                  r.error_valid = 1'b1;
                  r.error_kind  = ERR_MISALIGNED;
                  r.bus_action  = ACT_NACK;
                end
              end
            end else if ((ptr[LANE_W-1:0] & m) == '0) begin
              // group boundary reached: commit the buffered group
              base = ptr - m - 1'b1;
              for (k = 0; k <= int'(m); k++) mem_write(int'(base) + k, grp_bytes[k]);
            end
          end
        end
      end
      REQ_BYTE_TX: begin
        r.tx_valid = 1'b1;
        if (pos >= 0 && pos < int'(rd_limit)) begin
          if (m == GRP_MASK_1) begin
            r.tx_byte = mem_read(int'(ptr));
          end else begin
            // snapshot taken at the first byte of an aligned group
            if ((ptr[LANE_W-1:0] & m) == '0) begin
              for (k = 0; k <= int'(m); k++) grp_bytes[k] = mem_read(int'(ptr) + k);
            end
            r.tx_byte = grp_bytes[ptr[LANE_W-1:0] & m];
          end
          ptr = ptr + 1'b1;
        end
      end
      REQ_READ_NACK, REQ_STOP: ;
      REQ_BUS_ERROR: r.bus_action = ACT_RELEASE;
      REQ_FAULT: begin
        r.error_valid = 1'b1;
        r.error_kind  = ERR_BUS;
        r.bus_action  = ACT_NACK;
      end
      default: r.bus_action = ACT_NACK;
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [BYTE_W-1:0] want,
                                      input logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // watch both channels and the register port at every edge
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (mem_copy[i]) mem_copy[i] = '0;
      foreach (grp_bytes[i]) grp_bytes[i] = '0;
      ptr      = '0;
      grp_mask = GRP_MASK_1;
      rd_limit = '0;
      wr_limit = '0;
      replies_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_READABLE_LEN: rd_limit = cfg_wdata;
          CFG_WRITABLE_LEN: wr_limit = cfg_wdata;
          default: ;
        endcase
      end
      // result transfer against the oldest reply due
      if (out_mon.valid && out_mon.ready) begin
        if (replies_due.size() == 0) begin
          $error("result transfer with no reply due");
          mismatches++;
        end else begin
          due = replies_due.pop_front();
          check_field("bus_action", BYTE_W'(due.bus_action), BYTE_W'(out_mon.bus_action));
          check_field("tx_valid", BYTE_W'(due.tx_valid), BYTE_W'(out_mon.tx_valid));
          check_field("tx_byte", due.tx_byte, out_mon.tx_byte);
          check_field("signal_valid", BYTE_W'(due.signal_valid),
                      BYTE_W'(out_mon.signal_valid));
          check_field("signal_code", BYTE_W'(due.signal_code), BYTE_W'(out_mon.signal_code));
          check_field("error_valid", BYTE_W'(due.error_valid), BYTE_W'(out_mon.error_valid));
          check_field("error_kind", BYTE_W'(due.error_kind), BYTE_W'(out_mon.error_kind));
        end
      end
      if (in_mon.valid && in_mon.ready)
        replies_due.push_back(serve_event(in_mon.req_type, in_mon.rx_byte));
    end
    outstanding = replies_due.size();
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
  import igrf_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;
  localparam int QUIET_LIMIT  = 1000;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES       = 8;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_READABLE_LEN;
  logic [LEN_W-1:0]     cfg_wdata = '0;

  int mismatches;
  int outstanding;
  int sent_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  bit long_hold = 1'b0;

  // per phase: lengths, idling, stalls and number of events
  int phase_rd   [PHASES] = '{256, 0, 100, 8, 256, 255, 1, 256};
  int phase_wr   [PHASES] = '{256, 0, 37, 256, 9, 200, 1, 256};
  int phase_idle [PHASES] = '{0, 47, 0, 21, 47, 0, 21, 21};
  int phase_stall[PHASES] = '{0, 0, 47, 21, 0, 47, 21, 21};
  int phase_len  [PHASES] = '{120, 80, 130, 120, 110, 120, 60, 90};

  igrf_in_if  in_chan ();
  igrf_out_if out_chan ();

  i2c_target_grouped_register_file uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  igrf_reply_check reply_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one bus event, with random sender gaps ahead of it
  task automatic send_event(input logic [REQ_W-1:0] req, input logic [BYTE_W-1:0] b);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.req_type <= req;
    in_chan.rx_byte  <= b;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sent_count++;
  endtask

  // stop offering and wait until every reply has come back
  task automatic settle();
    in_chan.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic set_lengths(input logic [LEN_W-1:0] rd, input logic [LEN_W-1:0] wr);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_READABLE_LEN;
    cfg_wdata <= rd;
    @(posedge clk);
    cfg_index <= CFG_WRITABLE_LEN;
    cfg_wdata <= wr;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // address word: mostly aligned starts near the store, some misaligned,
  // far away or signal commands
  function automatic logic [INDEX_W-1:0] pick_address();
    int                 sel;
    int                 roll;
    logic [START_W-1:0] start;
    sel  = $urandom_range(3);
    roll = $urandom_range(99);
    if (roll < 6) return {13'h1FFF, 3'($urandom)};
    if (roll < 12) begin
      start = START_W'($urandom);
    end else begin
      start = START_W'($urandom_range(263));
      if (roll >= 22) start &= ~START_W'((1 << sel) - 1);
    end
    return {2'(sel), start};
  endfunction

  // well-formed write and read transactions with random content, plus noise
  task automatic run_traffic(input int target);
    int                 kind;
    int                 n;
    logic [INDEX_W-1:0] word;
    while (sent_count < target) begin
      kind = $urandom_range(99);
      if (kind < 80) begin
        word = pick_address();
        send_event(REQ_ADDR_MATCH, BYTE_W'($urandom));
        send_event(REQ_BYTE_RX, word[7:0]);
        // now and then the address word is cut short
        if ($urandom_range(9) != 0) send_event(REQ_BYTE_RX, word[15:8]);
        n = $urandom_range(12);
        repeat (n) send_event((kind < 45) ? REQ_BYTE_RX : REQ_BYTE_TX, BYTE_W'($urandom));
        if (kind >= 45) send_event(REQ_READ_NACK, BYTE_W'($urandom));
        send_event(($urandom_range(19) == 0) ? REQ_BUS_ERROR : REQ_STOP, BYTE_W'($urandom));
      end else begin
        send_event(REQ_W'($urandom_range(7)), BYTE_W'($urandom));
      end
    end
  endtask

  // receiver: random stalls, or one long hold-off on request
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        out_chan.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    in_chan.valid    = 1'b0;
    in_chan.req_type = REQ_STOP;
    in_chan.rx_byte  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    set_lengths(9'd256, 9'd256);

    // four byte group written at the top of the store
    send_event(REQ_ADDR_MATCH, 8'h00);
    send_event(REQ_BYTE_RX, 8'hFC);
    send_event(REQ_BYTE_RX, 8'h80);
    send_event(REQ_BYTE_RX, 8'hFF);
    send_event(REQ_BYTE_RX, 8'h00);
    send_event(REQ_BYTE_RX, 8'hA5);
    send_event(REQ_BYTE_RX, 8'h5A);
    // read it back, running into the readable limit
    send_event(REQ_ADDR_MATCH, 8'hFF);
    send_event(REQ_BYTE_RX, 8'hFC);
    send_event(REQ_BYTE_RX, 8'h80);
    repeat (5) send_event(REQ_BYTE_TX, 8'h00);
    send_event(REQ_READ_NACK, 8'h00);
    send_event(REQ_STOP, 8'h00);
    // misaligned group start
    send_event(REQ_ADDR_MATCH, 8'h00);
    send_event(REQ_BYTE_RX, 8'hFD);
    send_event(REQ_BYTE_RX, 8'h80);
    // signal command
    send_event(REQ_ADDR_MATCH, 8'h00);
    send_event(REQ_BYTE_RX, 8'hFF);
    send_event(REQ_BYTE_RX, 8'hFF);
    // bus error, fault and the unused code
    send_event(REQ_BUS_ERROR, 8'h00);
    send_event(REQ_FAULT, 8'h00);
    send_event(REQ_UNUSED, 8'h00);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle_pct = phase_idle[ph];
      stall_pct     = phase_stall[ph];
      set_lengths(LEN_W'(phase_rd[ph]), LEN_W'(phase_wr[ph]));
      // receiver holds off while events keep coming, so the block backs up
      if (phase_stall[ph] != 0 && phase_idle[ph] == 0) long_hold = 1'b1;
      run_traffic(sent_count + phase_len[ph]);
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/igrf_pkg.sv
rtl/igrf_in_if.sv
rtl/igrf_out_if.sv
rtl/igrf_store.sv
rtl/igrf_core.sv
rtl/i2c_target_grouped_register_file.sv
test/igrf_reply_check.sv
test/tb.sv
